// ===== hw/rtl/twf_pkg.sv =====
`default_nettype none

package twf_pkg;

	localparam int INDEX_BITS = 24;
	localparam int COORD_BITS = 24;

	// Configuration register widths and reset values.
	localparam int COS_W = 17;
	localparam int RAD_W = 23;
	localparam int CNT_W = 25;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = CNT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_COS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

	localparam logic [COS_W-1:0] COS_RESET = 17'd46341;
	localparam logic [COS_W-1:0] COS_ONE   = 17'd65536;

	// Squared cosine and squared radius.
	localparam int C2_W = 2 * COS_W - 1;
	localparam int R2_W = 2 * RAD_W;
	localparam logic [C2_W-1:0] C2_RESET = C2_W'(64'd46341 * 64'd46341);

	// The slope test compares ny^2 scaled by one squared Q1.16 unit.
	localparam int SLOPE_SHIFT = 2 * (COS_W - 1);

	// Index compare width.
	localparam int IXW = (INDEX_BITS > CNT_W) ? INDEX_BITS : CNT_W;

	// Datapath widths derived from the coordinate width.
	localparam int EW   = COORD_BITS + 1;        // edge component, signed
	localparam int PW   = 2 * COORD_BITS + 2;    // signed product and normal component
	localparam int NW   = 2 * COORD_BITS + 1;    // normal component magnitude
	localparam int SH   = (NW + 1) / 2;          // split point for squaring
	localparam int SQW  = 2 * NW;                // squared normal component
	localparam int N2W  = SQW + 2;               // squared normal length
	localparam int LQW  = 2 * COORD_BITS;        // squared edge component
	localparam int LW   = LQW + 2;               // squared edge length
	localparam int RH   = (R2_W + 1) / 2;
	localparam int LH   = (LW + 1) / 2;
	localparam int RLW  = R2_W + LW;             // radius^2 * longest edge^2
	localparam int CKN  = 4;                     // chunks of the squared normal length
	localparam int CKW  = (N2W + CKN - 1) / CKN;
	localparam int CNW  = C2_W + N2W;            // cos^2 * squared normal length
	localparam int NRW  = (N2W > RLW) ? N2W : RLW;

	typedef enum logic [2:0] {
		RSN_KEPT   = 3'd0,
		RSN_INDEX  = 3'd1,
		RSN_DEGEN  = 3'd2,
		RSN_STEEP  = 3'd3,
		RSN_NARROW = 3'd4
	} reason_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [INDEX_BITS-1:0] index_t;

endpackage

`default_nettype wire

// ===== hw/rtl/triangle_walkability_filter.sv =====
`default_nettype none

// Triangle walkability filter. One triangle is taken on every cycle in which
// start is high (busy is always low), and its verdict appears on walkable and
// reject_reason with a one-cycle done strobe, in input order; the block is a
// fixed nine-stage pipeline with no stalls, so the receiver must take every
// result when done is high. Configuration writes are taken on every cycle
// (cfg_ready is always high) and must only be made while no triangle is in
// flight; writes to an index past the last register are ignored.
module triangle_walkability_filter (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [twf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [twf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire                              start,
	output logic                             busy,
	input  wire  [twf_pkg::INDEX_BITS-1:0]   index_a,
	input  wire  [twf_pkg::INDEX_BITS-1:0]   index_b,
	input  wire  [twf_pkg::INDEX_BITS-1:0]   index_c,
	input  wire  signed [twf_pkg::COORD_BITS-1:0] ax,
	input  wire  signed [twf_pkg::COORD_BITS-1:0] ay,
	input  wire  signed [twf_pkg::COORD_BITS-1:0] az,
	input  wire  signed [twf_pkg::COORD_BITS-1:0] bx,
	input  wire  signed [twf_pkg::COORD_BITS-1:0] by_coord,
	input  wire  signed [twf_pkg::COORD_BITS-1:0] bz,
	input  wire  signed [twf_pkg::COORD_BITS-1:0] cx,
	input  wire  signed [twf_pkg::COORD_BITS-1:0] cy,
	input  wire  signed [twf_pkg::COORD_BITS-1:0] cz,
	output logic                             done,
	output logic                             walkable,
	output logic [2:0]                       reject_reason
);
	import twf_pkg::*;

	// Configuration registers and their squares.
	logic [COS_W-1:0]  cos_q;
	logic [RAD_W-1:0]  radius_q;
	logic [CNT_W-1:0]  count_q;
	logic [C2_W-1:0]   c2_q;
	logic [R2_W-1:0]   r2_q;
	logic [COS_W-1:0]  cos_sat;

	// Valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, done_s9;
	logic accept;

	// Stage 1: edges and the index check.
	logic signed [EW-1:0] e_d  [9];
	logic signed [EW-1:0] e_s1 [9];
	logic oor_d, oor_s1;

	// Stage 2: cross-product terms and squared edge components.
	logic signed [PW-1:0] cp_d  [6];
	logic signed [PW-1:0] cp_s2 [6];
	logic signed [PW-1:0] sqf_d [9];
	logic [LQW-1:0]       sq_s2 [9];
	logic oor_s2;

	// Stage 3: normal magnitudes and squared edge lengths.
	logic signed [PW-1:0] nd_d   [3];
	logic signed [PW-1:0] nabs_d [3];
	logic [NW-1:0]        nmag_s3 [3];
	logic [LW-1:0]        l_s3 [3];
	logic oor_s3;

	// Stage 4: partial squares of the normal, longest edge.
	logic [2*(NW-SH)-1:0] hh_s4 [3];
	logic [NW-1:0]        hl_s4 [3];
	logic [2*SH-1:0]      ll_s4 [3];
	logic [LW-1:0]        lmax_d, lmax_s4;
	logic oor_s4, zero_s4;

	// Stage 5: squared normal components, radius partial products.
	logic [SQW-1:0]             nsq_s5 [3];
	logic [RH+LH-1:0]           rll_s5;
	logic [RH+LW-LH-1:0]        rlh_s5;
	logic [R2_W-RH+LH-1:0]      rhl_s5;
	logic [R2_W-RH+LW-LH-1:0]   rhh_s5;
	logic oor_s5, zero_s5;

	// Stage 6: squared normal length and radius bound.
	logic [N2W-1:0] n2_s6;
	logic [SQW-1:0] ny2_s6;
	logic [RLW-1:0] rl_s6;
	logic oor_s6, zero_s6;

	// Stage 7: narrowness test, cosine partial products.
	logic [CKN*CKW-1:0]   n2p;
	logic [C2_W+CKW-1:0]  cn_s7 [CKN];
	logic [SQW-1:0]       ny2_s7;
	logic oor_s7, zero_s7, narrow_s7;

	// Stage 8: cosine bound assembled.
	logic [CNW-1:0] cn_d, cn_s8;
	logic [SQW-1:0] ny2_s8;
	logic oor_s8, zero_s8, narrow_s8;

	// Stage 9: result.
	logic    steep;
	reason_t reason_d;
	reason_t reason_s9;

	assign accept    = start;
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign cos_sat   = (cos_q > COS_ONE) ? COS_ONE : cos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= COS_RESET;
			radius_q <= '0;
			count_q  <= '0;
			c2_q     <= C2_RESET;
			r2_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_COS:    cos_q    <= cfg_data[COS_W-1:0];
					CFG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
					CFG_COUNT:  count_q  <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			c2_q <= C2_W'(cos_sat) * C2_W'(cos_sat);
			r2_q <= R2_W'(radius_q) * R2_W'(radius_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			v_s8    <= 1'b0;
			done_s9 <= 1'b0;
		end else begin
			v_s1    <= accept;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			v_s8    <= v_s7;
			done_s9 <= v_s8;
		end
	end

	// Stage 1.
	always_comb begin
		e_d[0] = EW'(bx) - EW'(ax);
		e_d[1] = EW'(by_coord) - EW'(ay);
		e_d[2] = EW'(bz) - EW'(az);
		e_d[3] = EW'(cx) - EW'(ax);
		e_d[4] = EW'(cy) - EW'(ay);
		e_d[5] = EW'(cz) - EW'(az);
		e_d[6] = EW'(cx) - EW'(bx);
		e_d[7] = EW'(cy) - EW'(by_coord);
		e_d[8] = EW'(cz) - EW'(bz);
		oor_d = (IXW'(index_a) >= IXW'(count_q)) || (IXW'(index_b) >= IXW'(count_q))
			|| (IXW'(index_c) >= IXW'(count_q));
	end

	always_ff @(posedge clk) begin
		e_s1   <= e_d;
		oor_s1 <= oor_d;
	end

	// Stage 2: edge order is (B-A) x,y,z, (C-A) x,y,z, (C-B) x,y,z.
	always_comb begin
		cp_d[0] = PW'(e_s1[1]) * PW'(e_s1[5]);
		cp_d[1] = PW'(e_s1[2]) * PW'(e_s1[4]);
		cp_d[2] = PW'(e_s1[2]) * PW'(e_s1[3]);
		cp_d[3] = PW'(e_s1[0]) * PW'(e_s1[5]);
		cp_d[4] = PW'(e_s1[0]) * PW'(e_s1[4]);
		cp_d[5] = PW'(e_s1[1]) * PW'(e_s1[3]);
		for (int i = 0; i < 9; i++) begin
			sqf_d[i] = PW'(e_s1[i]) * PW'(e_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		cp_s2  <= cp_d;
		for (int i = 0; i < 9; i++) begin
			sq_s2[i] <= sqf_d[i][LQW-1:0];
		end
		oor_s2 <= oor_s1;
	end

	// Stage 3.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nd_d[k]   = cp_s2[2*k] - cp_s2[2*k+1];
			nabs_d[k] = nd_d[k][PW-1] ? -nd_d[k] : nd_d[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			nmag_s3[k] <= nabs_d[k][NW-1:0];
			l_s3[k]    <= LW'(sq_s2[3*k]) + LW'(sq_s2[3*k+1]) + LW'(sq_s2[3*k+2]);
		end
		oor_s3 <= oor_s2;
	end

	// Stage 4: each normal magnitude is squared as two halves.
	always_comb begin
		lmax_d = l_s3[0];
		if (l_s3[2] > lmax_d) begin
			lmax_d = l_s3[2];
		end
		if (l_s3[1] > lmax_d) begin
			lmax_d = l_s3[1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			hh_s4[k] <= (2*(NW-SH))'(nmag_s3[k][NW-1:SH]) * (2*(NW-SH))'(nmag_s3[k][NW-1:SH]);
			hl_s4[k] <= NW'(nmag_s3[k][NW-1:SH]) * NW'(nmag_s3[k][SH-1:0]);
			ll_s4[k] <= (2*SH)'(nmag_s3[k][SH-1:0]) * (2*SH)'(nmag_s3[k][SH-1:0]);
		end
		lmax_s4 <= lmax_d;
		zero_s4 <= (nmag_s3[0] == '0) && (nmag_s3[1] == '0) && (nmag_s3[2] == '0);
		oor_s4  <= oor_s3;
	end

	// Stage 5.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			nsq_s5[k] <= (SQW'(hh_s4[k]) << (2*SH)) + (SQW'(hl_s4[k]) << (SH+1))
				+ SQW'(ll_s4[k]);
		end
		rll_s5 <= (RH+LH)'(r2_q[RH-1:0]) * (RH+LH)'(lmax_s4[LH-1:0]);
		rlh_s5 <= (RH+LW-LH)'(r2_q[RH-1:0]) * (RH+LW-LH)'(lmax_s4[LW-1:LH]);
		rhl_s5 <= (R2_W-RH+LH)'(r2_q[R2_W-1:RH]) * (R2_W-RH+LH)'(lmax_s4[LH-1:0]);
		rhh_s5 <= (R2_W-RH+LW-LH)'(r2_q[R2_W-1:RH])
			* (R2_W-RH+LW-LH)'(lmax_s4[LW-1:LH]);
		zero_s5 <= zero_s4;
		oor_s5  <= oor_s4;
	end

	// Stage 6.
	always_ff @(posedge clk) begin
		n2_s6  <= N2W'(nsq_s5[0]) + N2W'(nsq_s5[1]) + N2W'(nsq_s5[2]);
		ny2_s6 <= nsq_s5[1];
		rl_s6  <= RLW'(rll_s5) + (RLW'(rlh_s5) << LH) + (RLW'(rhl_s5) << RH)
			+ (RLW'(rhh_s5) << (RH+LH));
		zero_s6 <= zero_s5;
		oor_s6  <= oor_s5;
	end

	// Stage 7. A zero radius gives a zero bound, so the narrowness test never fires.
	assign n2p = (CKN*CKW)'(n2_s6);

	always_ff @(posedge clk) begin
		for (int j = 0; j < CKN; j++) begin
			cn_s7[j] <= (C2_W+CKW)'(c2_q) * (C2_W+CKW)'(n2p[j*CKW +: CKW]);
		end
		narrow_s7 <= NRW'(n2_s6) < NRW'(rl_s6);
		ny2_s7    <= ny2_s6;
		zero_s7   <= zero_s6;
		oor_s7    <= oor_s6;
	end

	// Stage 8.
	always_comb begin
		cn_d = '0;
		for (int j = 0; j < CKN; j++) begin
			cn_d = cn_d + (CNW'(cn_s7[j]) << (j*CKW));
		end
	end

	always_ff @(posedge clk) begin
		cn_s8     <= cn_d;
		ny2_s8    <= ny2_s7;
		narrow_s8 <= narrow_s7;
		zero_s8   <= zero_s7;
		oor_s8    <= oor_s7;
	end

	// Stage 9: the first failing test gives the reason.
	always_comb begin
		steep = (CNW'(ny2_s8) << SLOPE_SHIFT) < cn_s8;
		priority if (oor_s8) begin
			reason_d = RSN_INDEX;
		end else if (zero_s8) begin
			reason_d = RSN_DEGEN;
		end else if (steep) begin
			reason_d = RSN_STEEP;
		end else if (narrow_s8) begin
			reason_d = RSN_NARROW;
		end else begin
			reason_d = RSN_KEPT;
		end
	end

	always_ff @(posedge clk) begin
		reason_s9 <= reason_d;
	end

	assign done          = done_s9;
	assign walkable      = (reason_s9 == RSN_KEPT);
	assign reject_reason = reason_s9;

endmodule

`default_nettype wire
